[design/aadf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aadf_pkg
// Shared widths, register indexes, mode codes and types of the axis filter.
// ---------------------------------------------------------------------------
package aadf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int KSIZE_W  = 7;
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 3;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_FILTER_MODE = 3'd0;
  localparam logic [INDEX_W-1:0] REG_LOWER_BOUND = 3'd1;
  localparam logic [INDEX_W-1:0] REG_UPPER_BOUND = 3'd2;
  localparam logic [INDEX_W-1:0] REG_DEADZONE    = 3'd3;
  localparam logic [INDEX_W-1:0] REG_BLOCK_SIZE  = 3'd4;

  // filter modes
  localparam logic [MODE_W-1:0] MODE_DROP    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PASS    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AVERAGE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LAST    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } seq_state_t;

  // divider request: start pulse and sign of the dividend
  typedef struct packed {
    logic start;
    logic neg;
  } div_req_t;

endpackage

[design/aadf_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aadf_div
// Restoring divider, one quotient bit per cycle, signed result truncated
// toward zero from a magnitude dividend and a sign flag.
// ---------------------------------------------------------------------------
module aadf_div #(
  parameter int SUM_W = 22
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  aadf_pkg::div_req_t                req,
  input  logic [SUM_W-1:0]                  dividend_mag,
  input  logic [aadf_pkg::KSIZE_W-1:0]      divisor,
  output logic                              done,
  output logic signed [aadf_pkg::SAMPLE_W-1:0] quotient
);
  import aadf_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [KSIZE_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               neg_r, neg_nxt;

  logic [KSIZE_W:0]   shifted;
  logic [KSIZE_W+1:0] diff;
  logic               ge;
  logic [SUM_W-1:0]   quo_signed;

  // shared subtractor: one trial subtraction per cycle
  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};
  assign ge      = ~diff[KSIZE_W+1];

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    if (req.start) begin
      quo_nxt  = dividend_mag;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(SUM_W);
      busy_nxt = 1'b1;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[KSIZE_W-1:0] : shifted[KSIZE_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign quo_signed = neg_r ? (~quo_r + SUM_W'(1)) : quo_r;
  assign quotient   = quo_signed[SAMPLE_W-1:0];
  assign done       = done_r;

endmodule

[design/analog_axis_deadzone_filter_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// analog_axis_deadzone_filter_unit
// Deadzone and range gate on a signed axis stream, with a boxcar average or
// last-of-block decimator over a configured block size of accepted samples.
// ---------------------------------------------------------------------------
// Results: pass-through, last-of-block and size-one results go from the
//   result register through the emit step into the output register; block
//   averages pass through the bit-serial divider first.
// Throughput: one sample per cycle while it only adds to the block; a sample
//   that emits a result closes the input until the result is loaded.
// Reset: synchronous, active low; configuration registers, sum and count return to reset.
module analog_axis_deadzone_filter_unit #(
  parameter int MAX_KERNEL = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aadf_pkg::INDEX_W-1:0]        cfg_index,
  input  logic [aadf_pkg::SAMPLE_W-1:0]       cfg_data,
  // sample stream in
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [aadf_pkg::SAMPLE_W-1:0]       in_tdata,   // [15:0] sample
  // filtered stream out
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [aadf_pkg::SAMPLE_W-1:0]       out_tdata   // [15:0] filtered_value
);
  import aadf_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(MAX_KERNEL);
  localparam logic [8:0] MAX_K9 = 9'(MAX_KERNEL);

  // configuration registers
  logic [MODE_W-1:0]          mode_r;
  logic signed [SAMPLE_W-1:0] lower_r, upper_r;
  logic [SAMPLE_W-1:0]        deadzone_r;
  logic [KSIZE_W-1:0]         ksize_r;

  seq_state_t state_r, state_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [KSIZE_W-1:0]         cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0] res_r, res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]        out_data_r, out_data_nxt;

  logic                       in_fire, cfg_fire, cfg_hit;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W:0]   sample_x;
  logic [SAMPLE_W:0]          mag;
  logic                       keep;
  logic [KSIZE_W-1:0]         eff_size;
  logic signed [SUM_W-1:0]    sum_acc;
  logic [KSIZE_W-1:0]         cnt_inc;
  logic [SUM_W-1:0]           sum_mag;
  logic                       out_free;

  div_req_t                   div_req;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_quo;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && (cfg_index <= REG_BLOCK_SIZE);
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign sample   = in_tdata;
  assign sample_x = (SAMPLE_W + 1)'(sample);
  assign mag      = sample_x[SAMPLE_W] ? 17'(-sample_x) : 17'(sample_x);
  assign keep     = (mag >= {1'b0, deadzone_r}) && (sample >= lower_r) &&
                    (sample <= upper_r);

  always_comb begin
    if (ksize_r == '0) begin
      eff_size = KSIZE_W'(1);
    end else if ({2'b00, ksize_r} > MAX_K9) begin
      eff_size = MAX_K9[KSIZE_W-1:0];
    end else begin
      eff_size = ksize_r;
    end
  end

  assign sum_acc  = sum_r + SUM_W'(sample);
  assign cnt_inc  = cnt_r + KSIZE_W'(1);
  assign sum_mag  = sum_acc[SUM_W-1] ? (~sum_acc + SUM_W'(1)) : sum_acc;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    div_req.start = 1'b0;
    div_req.neg   = sum_acc[SUM_W-1];
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (mode_r == MODE_PASS) begin
            res_nxt   = sample;
            state_nxt = ST_EMIT;
          end else if (mode_r != MODE_DROP && keep) begin
            if (cnt_inc >= eff_size) begin
              sum_nxt = '0;
              cnt_nxt = '0;
              if (mode_r == MODE_LAST || eff_size == KSIZE_W'(1)) begin
                res_nxt   = sample;
                state_nxt = ST_EMIT;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = ST_DIV;
              end
            end else begin
              sum_nxt = sum_acc;
              cnt_nxt = cnt_inc;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt   = div_quo;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // a register write restarts the block
    if (cfg_hit) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_AVERAGE;
      lower_r     <= 16'sh8000;
      upper_r     <= 16'sh7FFF;
      deadzone_r  <= '0;
      ksize_r     <= KSIZE_W'(1);
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_FILTER_MODE: mode_r     <= cfg_data[MODE_W-1:0];
          REG_LOWER_BOUND: lower_r    <= cfg_data;
          REG_UPPER_BOUND: upper_r    <= cfg_data;
          REG_DEADZONE:    deadzone_r <= cfg_data;
          REG_BLOCK_SIZE:  ksize_r    <= cfg_data[KSIZE_W-1:0];
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  aadf_div #(
    .SUM_W(SUM_W)
  ) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (div_req),
    .dividend_mag (sum_mag),
    .divisor      (eff_size),
    .done         (div_done),
    .quotient     (div_quo)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[design/aadf_chk.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aadf_chk
// Port-level checks for the axis filter, bound onto the top level.
// ---------------------------------------------------------------------------
module aadf_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [aadf_pkg::SAMPLE_W-1:0] out_tdata
);
  import aadf_pkg::*;

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a new result is loaded only from the emit step, when input is closed
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without an emit step");

  // the emit step reopens the input right after loading
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("input not reopened after result load");

endmodule

bind analog_axis_deadzone_filter_unit aadf_chk u_aadf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
